>>> hdl/ogr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogr_pkg
// shared types, constants and helpers of the outlined glyph renderer
// ----------------------------------------------------------------------------
package ogr_pkg;

    localparam int GLYPH_SIZE = 8;
    localparam int GLYPH_BITS = GLYPH_SIZE * GLYPH_SIZE;

    localparam logic [7:0]         NEWLINE_CODE = 8'd10;
    localparam logic signed [10:0] CURSOR_MAX   = 11'sd1023;

    typedef enum logic [1:0] {
        CFG_MARGIN        = 2'd0,
        CFG_FILL_COLOR    = 2'd1,
        CFG_OUTLINE_COLOR = 2'd2
    } cfg_index_t;

    typedef logic signed [10:0] coord_t;

    // one character worth of pixel work, handed from the lanes to the merger
    typedef struct packed {
        logic [GLYPH_BITS-1:0] emit;
        logic [GLYPH_BITS-1:0] fill;
        coord_t                x0;
        coord_t                y0;
        coord_t                cursor_col;
        coord_t                cursor_row;
    } job_t;

    // cursor step of one glyph width, saturating at the top of the range
    function automatic coord_t sat_add8(input coord_t v);
        logic signed [11:0] s;
        s = {v[10], v} + 12'sd8;
        if (s > 12'sd1023)
            return CURSOR_MAX;
        else
            return s[10:0];
    endfunction

endpackage

>>> hdl/ogr_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogr_in_if
// character channel: one beat carries a character and its glyph bitmap
// ----------------------------------------------------------------------------
interface ogr_in_if;

    logic               valid;
    logic               ready;
    logic [7:0]         char_code;
    logic [63:0]        glyph_rows;
    logic               load_cursor;
    logic signed [10:0] start_x;
    logic signed [10:0] start_y;

    modport source (
        output valid, char_code, glyph_rows, load_cursor, start_x, start_y,
        input  ready
    );

    modport sink (
        input  valid, char_code, glyph_rows, load_cursor, start_x, start_y,
        output ready
    );

endinterface

>>> hdl/ogr_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogr_out_if
// pixel channel: one beat carries a pixel write or a null result
// ----------------------------------------------------------------------------
interface ogr_out_if;

    logic               valid;
    logic               ready;
    logic               write_enable;
    logic [8:0]         pixel_x;
    logic [7:0]         pixel_y;
    logic [15:0]        pixel_color;
    logic signed [10:0] cursor_col;
    logic signed [10:0] cursor_row;
    logic               last;

    modport source (
        output valid, write_enable, pixel_x, pixel_y, pixel_color,
               cursor_col, cursor_row, last,
        input  ready
    );

    modport sink (
        input  valid, write_enable, pixel_x, pixel_y, pixel_color,
               cursor_col, cursor_row, last,
        output ready
    );

endinterface

>>> hdl/outlined_glyph_renderer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// outlined_glyph_renderer
// 8x8 bitmap text renderer with outline and a saturating text cursor
// ----------------------------------------------------------------------------
// Each beat on the glyph channel is one character with its 8x8 bitmap. A
// newline moves the cursor to the margin and 8 rows down; any other character
// is drawn while the cursor row is above the last screen row, as fill pixels
// for set bits and outline pixels for clear bits next to a set bit, clipped to
// the screen, and then the cursor moves 8 columns right. The pixel channel
// gives one beat per pixel write in raster order, or one null beat when a
// character writes nothing; last marks the final beat of a character. A
// character gives max(1, writes) beats, up to 64; besides pixel back-pressure,
// the merger is the only limit on rate and emits one beat per cycle while not
// stalled. Characters pass the character stage, then the merger's job and
// output registers; the next is taken while the current one is being emitted.
// ----------------------------------------------------------------------------
module outlined_glyph_renderer
    import ogr_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 240
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    ogr_in_if.sink      glyph,
    ogr_out_if.source   pixel
);

    localparam logic signed [11:0] SCR_H = 12'(SCREEN_HEIGHT);

    // configuration
    logic [8:0]  margin_reg;
    logic [15:0] fill_color_reg;
    logic [15:0] outline_color_reg;

    // text cursor
    coord_t cursor_x_reg, cursor_x_next;
    coord_t cursor_y_reg, cursor_y_next;

    // character stage feeding the lanes
    logic        s1_valid_reg, s1_valid_next;
    logic        s1_draw_reg;
    logic [63:0] s1_glyph_reg;
    coord_t      s1_x0_reg;
    coord_t      s1_y0_reg;
    coord_t      s1_col_reg;
    coord_t      s1_row_reg;

    logic   accept;
    logic   s1_take;
    logic   is_newline;
    logic   draw;
    coord_t cur_x;
    coord_t cur_y;
    job_t   job;

    // ---- configuration writes ------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            margin_reg        <= '0;
            fill_color_reg    <= 16'hFFFF;
            outline_color_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_MARGIN:        margin_reg        <= cfg_wdata[8:0];
                CFG_FILL_COLOR:    fill_color_reg    <= cfg_wdata;
                CFG_OUTLINE_COLOR: outline_color_reg <= cfg_wdata;
                default:           ;
            endcase
        end
    end

    // ---- cursor update at acceptance -----------------------------------
    // the cursor only depends on earlier characters, so it settles at once
    assign glyph.ready = !s1_valid_reg || s1_take;
    assign accept      = glyph.valid && glyph.ready;

    always_comb
    begin
        cur_x      = glyph.load_cursor ? glyph.start_x : cursor_x_reg;
        cur_y      = glyph.load_cursor ? glyph.start_y : cursor_y_reg;
        is_newline = (glyph.char_code == NEWLINE_CODE);
        // rows above the screen still count as drawable
        draw       = !is_newline && ($signed({cur_y[10], cur_y}) < (SCR_H - 12'sd1));

        if (is_newline)
        begin
            cursor_x_next = {2'b00, margin_reg};
            cursor_y_next = sat_add8(cur_y);
        end
        else if (draw)
        begin
            cursor_x_next = sat_add8(cur_x);
            cursor_y_next = cur_y;
        end
        else
        begin
            // too far down: nothing drawn, cursor stays
            cursor_x_next = cur_x;
            cursor_y_next = cur_y;
        end

        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (s1_take)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg <= '0;
            cursor_y_reg <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (accept)
            begin
                cursor_x_reg <= cursor_x_next;
                cursor_y_reg <= cursor_y_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_draw_reg  <= draw;
            s1_glyph_reg <= glyph.glyph_rows;
            s1_x0_reg    <= cur_x;
            s1_y0_reg    <= cur_y;
            s1_col_reg   <= cursor_x_next;
            s1_row_reg   <= cursor_y_next;
        end
    end

    // ---- row lanes -----------------------------------------------------
    // one lane per glyph row, each sees the rows above and below for outline
    for (genvar r = 0; r < GLYPH_SIZE; r++)
    begin : g_lane
        logic [7:0] above;
        logic [7:0] below;
        logic [7:0] emit;
        logic [7:0] fill;

        if (r == 0)
        begin : g_top
            assign above = '0;
        end
        else
        begin : g_inner_top
            assign above = s1_glyph_reg[GLYPH_BITS-1-GLYPH_SIZE*(r-1) -: GLYPH_SIZE];
        end

        if (r == GLYPH_SIZE - 1)
        begin : g_bottom
            assign below = '0;
        end
        else
        begin : g_inner_bottom
            assign below = s1_glyph_reg[GLYPH_BITS-1-GLYPH_SIZE*(r+1) -: GLYPH_SIZE];
        end

        ogr_lane #(
            .SCREEN_WIDTH  (SCREEN_WIDTH),
            .SCREEN_HEIGHT (SCREEN_HEIGHT),
            .ROW           (r)
        ) u_lane (
            .row_above (above),
            .row_bits  (s1_glyph_reg[GLYPH_BITS-1-GLYPH_SIZE*r -: GLYPH_SIZE]),
            .row_below (below),
            .x0        (s1_x0_reg),
            .y0        (s1_y0_reg),
            .emit      (emit),
            .fill      (fill)
        );

        // a character that is not drawn gives an empty mask, hence a null beat
        assign job.emit[r*GLYPH_SIZE +: GLYPH_SIZE] = emit & {GLYPH_SIZE{s1_draw_reg}};
        assign job.fill[r*GLYPH_SIZE +: GLYPH_SIZE] = fill;
    end

    assign job.x0         = s1_x0_reg;
    assign job.y0         = s1_y0_reg;
    assign job.cursor_col = s1_col_reg;
    assign job.cursor_row = s1_row_reg;

    // ---- merger: one beat per cycle unless stalled, raster order ---------
    ogr_merge u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .job_valid     (s1_valid_reg),
        .job           (job),
        .job_take      (s1_take),
        .fill_color    (fill_color_reg),
        .outline_color (outline_color_reg),
        .pixel         (pixel)
    );

endmodule

>>> hdl/ogr_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogr_lane
// one glyph row: classifies its eight pixels as fill or outline and clips them
// ----------------------------------------------------------------------------
module ogr_lane
    import ogr_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 240,
    parameter int ROW           = 0
)
(
    input  logic [7:0] row_above,   // bit 7 is the leftmost column
    input  logic [7:0] row_bits,
    input  logic [7:0] row_below,
    input  coord_t     x0,
    input  coord_t     y0,
    output logic [7:0] emit,        // bit c is column c
    output logic [7:0] fill
);

    localparam logic signed [11:0] SCR_W = 12'(SCREEN_WIDTH);
    localparam logic signed [11:0] SCR_H = 12'(SCREEN_HEIGHT);

    logic [7:0]         above_c;
    logic [7:0]         mid_c;
    logic [7:0]         below_c;
    logic [7:0]         near;
    logic [7:0]         spread;
    logic [7:0]         col_ok;
    logic               row_ok;
    logic signed [11:0] py;
    logic signed [11:0] px [GLYPH_SIZE];

    always_comb
    begin
        for (int c = 0; c < GLYPH_SIZE; c++)
        begin
            above_c[c] = row_above[GLYPH_SIZE-1-c];
            mid_c[c]   = row_bits[GLYPH_SIZE-1-c];
            below_c[c] = row_below[GLYPH_SIZE-1-c];
        end
        // the centre bit only matters where it is set, and then it is fill anyway
        near   = above_c | mid_c | below_c;
        spread = near | {near[6:0], 1'b0} | {1'b0, near[7:1]};

        py     = {y0[10], y0} + 12'(ROW);
        row_ok = (py >= 12'sd0) && (py < SCR_H);
        for (int c = 0; c < GLYPH_SIZE; c++)
        begin
            px[c]     = {x0[10], x0} + 12'(c);
            col_ok[c] = (px[c] >= 12'sd0) && (px[c] < SCR_W);
        end

        emit = (mid_c | spread) & col_ok & {8{row_ok}};
        fill = mid_c;
    end

endmodule

>>> hdl/ogr_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogr_merge
// walks a character's pixel mask in raster order, one result beat per cycle unless stalled
// ----------------------------------------------------------------------------
module ogr_merge
    import ogr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        job_valid,
    input  job_t        job,
    output logic        job_take,
    input  logic [15:0] fill_color,
    input  logic [15:0] outline_color,
    ogr_out_if.source   pixel
);

    logic        busy_reg, busy_next;
    job_t        job_reg, job_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_we_reg;
    logic [8:0]  out_x_reg;
    logic [7:0]  out_y_reg;
    logic [15:0] out_color_reg;
    coord_t      out_col_reg;
    coord_t      out_row_reg;
    logic        out_last_reg;

    logic                  advance;
    logic                  done;
    logic                  null_job;
    logic [7:0]            row_nz;
    logic [2:0]            sel_row;
    logic [2:0]            sel_col;
    logic [7:0]            sel_byte;
    logic [5:0]            idx;
    logic [GLYPH_BITS-1:0] mask_next;
    logic signed [11:0]    sum_x;
    logic signed [11:0]    sum_y;

    always_comb
    begin
        for (int r = 0; r < GLYPH_SIZE; r++)
            row_nz[r] = |job_reg.emit[r*GLYPH_SIZE +: GLYPH_SIZE];
        sel_row = '0;
        for (int r = GLYPH_SIZE - 1; r >= 0; r--)
            if (row_nz[r])
                sel_row = 3'(r);
        sel_byte = job_reg.emit[sel_row*GLYPH_SIZE +: GLYPH_SIZE];
        sel_col  = '0;
        for (int c = GLYPH_SIZE - 1; c >= 0; c--)
            if (sel_byte[c])
                sel_col = 3'(c);
        idx = {sel_row, sel_col};

        null_job  = (job_reg.emit == '0);
        mask_next = job_reg.emit & ~(GLYPH_BITS'(1) << idx);
        done      = (mask_next == '0);

        sum_x = {job_reg.x0[10], job_reg.x0} + 12'(sel_col);
        sum_y = {job_reg.y0[10], job_reg.y0} + 12'(sel_row);

        advance  = busy_reg && (!out_valid_reg || pixel.ready);
        job_take = job_valid && (!busy_reg || (advance && done));

        busy_next = busy_reg;
        job_next  = job_reg;
        if (job_take)
        begin
            busy_next = 1'b1;
            job_next  = job;
        end
        else if (advance)
        begin
            busy_next     = !done;
            job_next.emit = mask_next;
        end

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (pixel.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        if (advance)
        begin
            out_col_reg  <= job_reg.cursor_col;
            out_row_reg  <= job_reg.cursor_row;
            out_last_reg <= done;
            if (null_job)
            begin
                out_we_reg    <= 1'b0;
                out_x_reg     <= '0;
                out_y_reg     <= '0;
                out_color_reg <= '0;
            end
            else
            begin
                out_we_reg    <= 1'b1;
                out_x_reg     <= sum_x[8:0];
                out_y_reg     <= sum_y[7:0];
                out_color_reg <= job_reg.fill[idx] ? fill_color : outline_color;
            end
        end
    end

    assign pixel.valid        = out_valid_reg;
    assign pixel.write_enable = out_we_reg;
    assign pixel.pixel_x      = out_x_reg;
    assign pixel.pixel_y      = out_y_reg;
    assign pixel.pixel_color  = out_color_reg;
    assign pixel.cursor_col   = out_col_reg;
    assign pixel.cursor_row   = out_row_reg;
    assign pixel.last         = out_last_reg;

endmodule
